@@ rtl/core/sacc_pkg.sv @@
package sacc_pkg;

	localparam int unsigned DEF_MAX_SETS = 256;
	localparam int unsigned DEF_MAX_WAYS = 8;
	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned TAG_W        = 30;
	localparam int unsigned COST_W       = 17;
	localparam int unsigned CNT_W        = 32;
	localparam int unsigned CYC_W        = 48;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOC     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WB        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LRU       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_PEN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_CYC   = 3'd7;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // capture input transaction
		logic clr_step;   // clearing pass: write one set of metadata to zero
		logic rd_set;     // read the set memory
		logic compute;    // evaluate lookup, costs, next metadata
		logic commit;     // write tags, metadata and counters, load output register
	} sacc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
	} sacc_sts_t;

endpackage

@@ rtl/core/sacc_datapath.sv @@
module sacc_datapath #(
	parameter int unsigned MAX_SETS = sacc_pkg::DEF_MAX_SETS,
	parameter int unsigned MAX_WAYS = sacc_pkg::DEF_MAX_WAYS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sacc_pkg::sacc_cmd_t                  cmd,
	output sacc_pkg::sacc_sts_t                  sts,
	input  logic                                 cfg_we,
	input  logic [sacc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [sacc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_op,
	input  logic [sacc_pkg::ADDR_W-1:0]          in_address,
	output logic                                 o_hit,
	output logic [sacc_pkg::COST_W-1:0]          o_cost,
	output logic                                 o_dirty_ev,
	output logic [sacc_pkg::CNT_W-1:0]           o_loads,
	output logic [sacc_pkg::CNT_W-1:0]           o_stores,
	output logic [sacc_pkg::CNT_W-1:0]           o_ld_hit_cnt,
	output logic [sacc_pkg::CNT_W-1:0]           o_ld_miss_cnt,
	output logic [sacc_pkg::CNT_W-1:0]           o_st_hit_cnt,
	output logic [sacc_pkg::CNT_W-1:0]           o_st_miss_cnt,
	output logic [sacc_pkg::CYC_W-1:0]           o_cycles
);
	import sacc_pkg::*;

	localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned MAXSB  = $clog2(MAX_SETS + 1) - 1;
	localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned FILL_W = $clog2(MAX_WAYS + 1);
	localparam int unsigned META_W = 2 + WAY_W;

	typedef logic [META_W-1:0] meta_t;   // {valid, dirty, rank}

	// configuration
	logic [3:0] set_bits_q, ways_q, hit_cyc_q;
	logic [2:0] word_bits_q;
	logic       alloc_q, wb_q, lru_q;
	logic [9:0] mem_pen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q  <= '0;
			ways_q      <= 4'd1;
			word_bits_q <= '0;
			alloc_q     <= 1'b0;
			wb_q        <= 1'b0;
			lru_q       <= 1'b0;
			mem_pen_q   <= 10'd100;
			hit_cyc_q   <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SET_BITS:  set_bits_q  <= cfg_data[3:0];
				REG_WAYS:      ways_q      <= cfg_data[3:0];
				REG_WORD_BITS: word_bits_q <= cfg_data[2:0];
				REG_ALLOC:     alloc_q     <= cfg_data[0];
				REG_WB:        wb_q        <= cfg_data[0];
				REG_LRU:       lru_q       <= cfg_data[0];
				REG_MEM_PEN:   mem_pen_q   <= cfg_data[9:0];
				REG_HIT_CYC:   hit_cyc_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// captured transaction and address split
	logic                op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SET_W-1:0]    set_q;
	logic [TAG_W-1:0]    tag_q;
	logic [16:0]         blockpen_q;

	logic [2:0]          wb_eff;
	logic [3:0]          sb_eff;
	logic [3:0]          ways_eff;
	logic [4:0]          off;
	logic [ADDR_W-1:0]   set_full, tag_full;

	always_comb begin
		wb_eff   = (word_bits_q > 3'd6) ? 3'd6 : word_bits_q;
		sb_eff   = (set_bits_q > 4'(MAXSB)) ? 4'(MAXSB) : set_bits_q;
		ways_eff = (ways_q == 4'd0) ? 4'd1 : ways_q;
		if (5'(ways_eff) > 5'(MAX_WAYS))
			ways_eff = 4'(MAX_WAYS);
		off      = 5'(wb_eff) + 5'd2;
		set_full = (addr_q >> off) & ((ADDR_W'(1) << sb_eff) - ADDR_W'(1));
		tag_full = addr_q >> (off + 5'(sb_eff));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= in_op;
			addr_q <= in_address;
		end
		if (cmd.rd_set) begin
			set_q      <= set_full[SET_W-1:0];
			tag_q      <= tag_full[TAG_W-1:0];
			blockpen_q <= 17'(mem_pen_q) << wb_eff;
		end
	end

	// set memories: tags (no reset) and metadata (cleared by a pass)
	logic [MAX_WAYS*TAG_W-1:0]  tag_mem  [MAX_SETS];
	logic [MAX_WAYS*META_W-1:0] meta_mem [MAX_SETS];
	logic [MAX_WAYS*TAG_W-1:0]  tag_rd_q;
	logic [MAX_WAYS*META_W-1:0] meta_rd_q;
	logic [MAX_WAYS*TAG_W-1:0]  tag_wr_s2;
	logic [MAX_WAYS*META_W-1:0] meta_wr_s2;
	logic [SET_W:0]             clr_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_set) begin
			tag_rd_q  <= tag_mem[set_full[SET_W-1:0]];
			meta_rd_q <= meta_mem[set_full[SET_W-1:0]];
		end
		if (cmd.clr_step)
			meta_mem[clr_cnt_q[SET_W-1:0]] <= '0;
		else if (cmd.commit) begin
			tag_mem[set_q]  <= tag_wr_s2;
			meta_mem[set_q] <= meta_wr_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_step && !clr_cnt_q[SET_W])
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end
	assign sts.clr_done = (clr_cnt_q == (SET_W+1)'(MAX_SETS));

	// lookup and update
	logic                 hit_c, dev_c, alloc_c, mark_dirty_c, promote_c;
	logic [WAY_W-1:0]     hway_c, slot_c, pway_c, rsel;
	logic [FILL_W-1:0]    fill_c;
	logic [COST_W+1:0]    cost_c;
	logic [MAX_WAYS-1:0]  vld, drt;
	logic [WAY_W-1:0]     rnk [MAX_WAYS];
	logic                 found, free_found;
	logic [MAX_WAYS*TAG_W-1:0]  tag_n;
	logic [MAX_WAYS*META_W-1:0] meta_n;
	logic [WAY_W-1:0]     rnk_n [MAX_WAYS];
	logic [MAX_WAYS-1:0]  vld_n, drt_n;
	logic [WAY_W-1:0]     newrank;

	always_comb begin
		hit_c = 1'b0; hway_c = '0; fill_c = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			vld[w] = meta_rd_q[w*META_W + META_W-1];
			drt[w] = meta_rd_q[w*META_W + WAY_W];
			rnk[w] = meta_rd_q[w*META_W +: WAY_W];
			if (vld[w])
				fill_c = fill_c + 1'b1;
		end
		for (int w = MAX_WAYS-1; w >= 0; w--)
			if (vld[w] && tag_rd_q[w*TAG_W +: TAG_W] == tag_q) begin
				hit_c  = 1'b1;
				hway_c = WAY_W'(w);
			end
		// victim: oldest valid way; free slot: first invalid way
		found = 1'b0; rsel = '0; free_found = 1'b0; slot_c = '0;
		for (int w = 0; w < MAX_WAYS; w++)
			if (vld[w] && (!found || rnk[w] < rnk[rsel])) begin
				rsel  = WAY_W'(w);
				found = 1'b1;
			end

		alloc_c = !hit_c && (op_q == OP_LOAD || alloc_q);
		mark_dirty_c = (op_q == OP_STORE) && wb_q && (hit_c || alloc_c);
		dev_c = 1'b0;
		promote_c = 1'b0;
		pway_c = hway_c;
		if (alloc_c) begin
			if (32'(fill_c) >= 32'(ways_eff)) begin
				slot_c    = rsel;
				dev_c     = drt[rsel] && wb_q;
				promote_c = 1'b1;
				pway_c    = rsel;
			end else begin
				for (int w = MAX_WAYS-1; w >= 0; w--)
					if (!vld[w]) begin
						slot_c = WAY_W'(w);
						free_found = 1'b1;
					end
			end
		end else if (hit_c && lru_q) begin
			promote_c = 1'b1;
		end

		for (int w = 0; w < MAX_WAYS; w++) begin
			rnk_n[w] = rnk[w];
			vld_n[w] = vld[w];
			drt_n[w] = drt[w];
		end
		newrank = WAY_W'(fill_c - 1'b1);
		if (promote_c) begin
			for (int w = 0; w < MAX_WAYS; w++)
				if (vld[w] && rnk[w] > rnk[pway_c])
					rnk_n[w] = rnk[w] - 1'b1;
			rnk_n[pway_c] = newrank;
		end
		tag_n = tag_rd_q;
		if (alloc_c) begin
			if (free_found)
				rnk_n[slot_c] = WAY_W'(fill_c);
			tag_n[slot_c*TAG_W +: TAG_W] = tag_q;
			vld_n[slot_c] = 1'b1;
			drt_n[slot_c] = mark_dirty_c;
		end else if (hit_c && mark_dirty_c) begin
			drt_n[hway_c] = 1'b1;
		end
		for (int w = 0; w < MAX_WAYS; w++)
			meta_n[w*META_W +: META_W] = {vld_n[w], drt_n[w], rnk_n[w]};

		// cost
		if (op_q == OP_LOAD)
			cost_c = hit_c ? 19'(hit_cyc_q) : 19'(hit_cyc_q) + 19'(blockpen_q);
		else if (hit_c)
			cost_c = wb_q ? 19'(hit_cyc_q) : 19'(hit_cyc_q) + 19'(mem_pen_q);
		else if (!alloc_q)
			cost_c = 19'(mem_pen_q);
		else if (wb_q)
			cost_c = 19'(hit_cyc_q) + 19'(blockpen_q);
		else
			cost_c = 19'(hit_cyc_q) + 19'(mem_pen_q) + 19'(blockpen_q);
		if (dev_c)
			cost_c = cost_c + 19'(blockpen_q);
	end

	// registered results of the compute step
	logic              hit_s2, dev_s2;
	logic [COST_W-1:0] cost_s2;

	always_ff @(posedge clk) begin
		if (cmd.compute) begin
			hit_s2     <= hit_c;
			dev_s2     <= dev_c;
			cost_s2    <= (cost_c > 19'h1FFFF) ? 17'h1FFFF : cost_c[COST_W-1:0];
			tag_wr_s2  <= tag_n;
			meta_wr_s2 <= meta_n;
		end
	end

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	logic [CYC_W:0] cyc_sum;
	assign cyc_sum = {1'b0, o_cycles} + (CYC_W+1)'(cost_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_loads <= '0; o_stores <= '0; o_ld_hit_cnt <= '0; o_ld_miss_cnt <= '0;
			o_st_hit_cnt <= '0; o_st_miss_cnt <= '0; o_cycles <= '0;
		end else if (cmd.commit) begin
			if (op_q == OP_LOAD) begin
				o_loads <= inc_sat(o_loads);
				if (hit_s2) o_ld_hit_cnt <= inc_sat(o_ld_hit_cnt);
				else        o_ld_miss_cnt <= inc_sat(o_ld_miss_cnt);
			end else begin
				o_stores <= inc_sat(o_stores);
				if (hit_s2) o_st_hit_cnt <= inc_sat(o_st_hit_cnt);
				else        o_st_miss_cnt <= inc_sat(o_st_miss_cnt);
			end
			o_cycles <= cyc_sum[CYC_W] ? {CYC_W{1'b1}} : cyc_sum[CYC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_hit      <= hit_s2;
			o_cost     <= cost_s2;
			o_dirty_ev <= dev_s2;
		end
	end

endmodule

@@ rtl/core/sacc_ctrl.sv @@
module sacc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output sacc_pkg::sacc_cmd_t cmd,
	input  sacc_pkg::sacc_sts_t sts
);
	import sacc_pkg::*;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_COMMIT} state_t;
	state_t state_q;

	// output register free when it is empty or being taken downstream
	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	assign s_tready     = (state_q == ST_IDLE);
	assign cmd.load_in  = s_tready && s_tvalid;
	assign cmd.clr_step = (state_q == ST_CLEAR) && !sts.clr_done;
	assign cmd.rd_set   = (state_q == ST_READ);
	assign cmd.compute  = (state_q == ST_EVAL);
	assign cmd.commit   = (state_q == ST_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			m_tvalid <= 1'b0;
		end else begin
			// a commit reloads the output; otherwise it holds until taken
			m_tvalid <= cmd.commit || (m_tvalid && !m_tready);
			unique case (state_q)
				ST_CLEAR:  if (sts.clr_done) state_q <= ST_IDLE;
				ST_IDLE:   if (s_tvalid) state_q <= ST_READ;
				ST_READ:   state_q <= ST_EVAL;
				ST_EVAL:   state_q <= ST_COMMIT;
				ST_COMMIT: if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/set_assoc_cache_cycle_model_top.sv @@
// Set-associative cache tag and timing model. Each slave transaction is one
// load or store address; each master transaction reports hit, the cycles the
// access costs, whether a dirty block was evicted, and saturating running
// counters. An accepted access passes through the set read, the compare and
// update, and the write of the set row with the output register; the next
// access is taken in the cycle after the result has been loaded into the
// output register, so the block takes no new access while one is in progress.
// A result left waiting holds the access in the write stage until the output
// register is taken.
// The set row is a read-modify-write on a single-port memory per field group.
// After reset a clearing pass zeroes the valid, dirty and rank metadata of
// every set, and the slave side opens in the cycle after the pass counter
// reaches MAX_SETS; no access is taken meanwhile, but configuration writes are.
// The user must write configuration only while idle; the block does not enforce it.
module set_assoc_cache_cycle_model_top #(
	parameter int unsigned MAX_SETS = sacc_pkg::DEF_MAX_SETS,
	parameter int unsigned MAX_WAYS = sacc_pkg::DEF_MAX_WAYS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [9:0]    cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,   // op[0], address[32:1], zero pad
	output logic          m_tvalid,
	input  logic          m_tready,
	// hit[0], cycles_added[17:1], dirty_evicted[18], loads[50:19], stores[82:51],
	// load hits[114:83], load misses[146:115], store hits[178:147],
	// store misses[210:179], cycles_so_far[258:211], zero pad
	output logic [263:0]  m_tdata
);
	import sacc_pkg::*;

	sacc_cmd_t cmd;
	sacc_sts_t sts;

	logic              o_hit, o_dev;
	logic [COST_W-1:0] o_cost;
	logic [CNT_W-1:0]  c_l, c_s, c_lh, c_lm, c_sh, c_sm;
	logic [CYC_W-1:0]  c_cyc;

	sacc_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd, .sts
	);

	sacc_datapath #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.cfg_we, .cfg_idx, .cfg_data,
		.in_op(s_tdata[0]), .in_address(s_tdata[32:1]),
		.o_hit, .o_cost, .o_dirty_ev(o_dev),
		.o_loads(c_l), .o_stores(c_s), .o_ld_hit_cnt(c_lh), .o_ld_miss_cnt(c_lm),
		.o_st_hit_cnt(c_sh), .o_st_miss_cnt(c_sm), .o_cycles(c_cyc)
	);

	assign m_tdata = {5'd0, c_cyc, c_sm, c_sh, c_lm, c_lh, c_s, c_l, o_dev, o_cost, o_hit};

endmodule

@@ tb/sv/tb.sv @@
module tb;
	import sacc_pkg::*;

	localparam int unsigned NSETS = DEF_MAX_SETS;
	localparam int unsigned NWAYS = DEF_MAX_WAYS;
	localparam int unsigned LIMIT_CYCLES = 600000;

	typedef struct {
		logic        op;
		logic [31:0] addr;
	} access_t;

	typedef struct {
		logic                hit;
		logic [COST_W-1:0]   cost;
		logic                dirty_ev;
		logic [CNT_W-1:0]    loads, stores, ld_hit_n, ld_miss_n, st_hit_n, st_miss_n;
		logic [CYC_W-1:0]    cycles;
	} outcome_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [2:0]    cfg_idx;
	logic [9:0]    cfg_data;
	logic          s_tvalid;
	logic          s_tready;
	logic [39:0]   s_tdata;   // op[0], address[32:1], zero pad
	logic          m_tvalid;
	logic          m_tready;
	// hit[0], cycles_added[17:1], dirty_evicted[18], loads[50:19], stores[82:51],
	// load hits[114:83], load misses[146:115], store hits[178:147],
	// store misses[210:179], cycles_so_far[258:211], zero pad
	logic [263:0]  m_tdata;

	set_assoc_cache_cycle_model_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow of the cache tag state and configuration
	logic [31:0]  tags  [NSETS*NWAYS];
	bit           vld   [NSETS*NWAYS];
	bit           drt   [NSETS*NWAYS];
	int unsigned  rank  [NSETS*NWAYS];
	int unsigned  c_sb, c_ways, c_wb, c_alloc, c_wbmode, c_lru, c_pen, c_hit;
	logic [CNT_W-1:0] n_ld, n_st, n_ldh, n_ldm, n_sth, n_stm;
	longint unsigned  n_cyc;

	access_t  pending[$];     // transactions waiting for the driver
	outcome_t expected[$];    // outcomes waiting for the monitor
	int       errors;
	bit       quiet;          // no idling in the closing stretch
	bit       hold_req;       // ask the monitor for one long back-pressure stretch
	bit       hold_done;
	longint   cyc;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 1;
	endfunction

	function automatic int unsigned set_fill(int unsigned base);
		int unsigned n;
		n = 0;
		for (int w = 0; w < NWAYS; w++) if (vld[base+w]) n++;
		return n;
	endfunction

	// move a way to most recent in its set
	function automatic void make_recent(int unsigned base, int unsigned way);
		int unsigned f, r;
		f = set_fill(base);
		r = rank[base+way];
		for (int w = 0; w < NWAYS; w++)
			if (vld[base+w] && rank[base+w] > r) rank[base+w]--;
		rank[base+way] = f - 1;
	endfunction

	// allocate a tag; evicts only the single oldest block when the set is full
	function automatic int unsigned allocate(int unsigned base, logic [31:0] tag,
			int unsigned ways, output bit dirty_out);
		int unsigned slot, f;
		bit found;
		slot = 0;
		found = 0;
		dirty_out = 0;
		f = set_fill(base);
		if (f >= ways) begin
			for (int w = 0; w < NWAYS; w++)
				if (vld[base+w] && (!found || rank[base+w] < rank[base+slot])) begin
					slot = w;
					found = 1;
				end
			if (drt[base+slot] && c_wbmode != 0) dirty_out = 1;
			make_recent(base, slot);
		end else begin
			for (int w = NWAYS-1; w >= 0; w--) if (!vld[base+w]) slot = w;
			rank[base+slot] = f;
		end
		tags[base+slot] = tag;
		vld[base+slot] = 1;
		drt[base+slot] = 0;
		return slot;
	endfunction

	function automatic outcome_t cache_access(access_t a);
		outcome_t o;
		int unsigned sb, ways, wb, off, set, base, hw, pen, cost, slot;
		logic [31:0] tag;
		bit hit, dev;
		sb   = (c_sb > 8) ? 8 : c_sb;
		ways = (c_ways == 0) ? 1 : ((c_ways > NWAYS) ? NWAYS : c_ways);
		wb   = (c_wb > 6) ? 6 : c_wb;
		off  = wb + 2;
		set  = (a.addr >> off) & ((1 << sb) - 1);
		tag  = a.addr >> (off + sb);
		base = set * NWAYS;
		pen  = c_pen << wb;
		hit  = 0;
		hw   = 0;
		dev  = 0;
		cost = 0;
		for (int w = NWAYS-1; w >= 0; w--)
			if (vld[base+w] && tags[base+w] == tag) begin
				hit = 1;
				hw = w;
			end
		if (a.op == OP_LOAD) begin
			n_ld = sat_inc(n_ld);
			if (hit) begin
				n_ldh = sat_inc(n_ldh);
				cost = c_hit;
				if (c_lru != 0) make_recent(base, hw);
			end else begin
				n_ldm = sat_inc(n_ldm);
				cost = c_hit + pen;
				slot = allocate(base, tag, ways, dev);
			end
		end else begin
			n_st = sat_inc(n_st);
			if (hit) begin
				n_sth = sat_inc(n_sth);
				if (c_wbmode != 0) begin
					cost = c_hit;
					drt[base+hw] = 1;
				end else
					cost = c_hit + c_pen;
				if (c_lru != 0) make_recent(base, hw);
			end else begin
				n_stm = sat_inc(n_stm);
				if (c_alloc == 0)
					cost = c_pen;
				else if (c_wbmode != 0) begin
					cost = c_hit + pen;
					slot = allocate(base, tag, ways, dev);
					drt[base+slot] = 1;
				end else begin
					cost = c_hit + c_pen + pen;
					slot = allocate(base, tag, ways, dev);
				end
			end
		end
		if (dev) cost += pen;
		if (cost > 32'h1FFFF) cost = 32'h1FFFF;
		n_cyc += cost;
		if (n_cyc > 48'hFFFF_FFFF_FFFF) n_cyc = 48'hFFFF_FFFF_FFFF;
		o.hit = hit;
		o.cost = cost[COST_W-1:0];
		o.dirty_ev = dev;
		o.loads = n_ld;
		o.stores = n_st;
		o.ld_hit_n = n_ldh;
		o.ld_miss_n = n_ldm;
		o.st_hit_n = n_sth;
		o.st_miss_n = n_stm;
		o.cycles = n_cyc[CYC_W-1:0];
		return o;
	endfunction

	// driver: presents pending transactions, predicts each one as it is accepted
	access_t cur;
	int      s_gap;
	always @(posedge clk or negedge arst_n) begin
		bit v;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_gap = 0;
		end else begin
			v = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected.insert(expected.size(), cache_access(cur));
				v = 0;
			end
			if (!v) begin
				if (s_gap > 0)
					s_gap--;
				else if (pending.size() > 0) begin
					cur = pending[0];
					pending.delete(0);
					s_tdata <= {7'b0, cur.addr, cur.op};
					v = 1;
					if (!quiet && $urandom_range(0, 6) == 0) s_gap = $urandom_range(1, 18);
				end
			end
			s_tvalid <= v;
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	int m_stall, m_long;
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		bit r;
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_stall = 0;
			m_long = 0;
			hold_done = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, m_tdata);
					errors++;
				end else begin
					e = expected[0];
					expected.delete(0);
					if (m_tdata[0] !== e.hit) begin
						$display("%0t: hit exp %0d act %0d", $time, e.hit, m_tdata[0]);
						errors++;
					end
					if (m_tdata[17:1] !== e.cost) begin
						$display("%0t: cycles_added exp %0d act %0d", $time, e.cost, m_tdata[17:1]);
						errors++;
					end
					if (m_tdata[18] !== e.dirty_ev) begin
						$display("%0t: dirty_evicted exp %0d act %0d", $time, e.dirty_ev,
							m_tdata[18]);
						errors++;
					end
					if (m_tdata[50:19] !== e.loads) begin
						$display("%0t: loads exp %0d act %0d", $time, e.loads, m_tdata[50:19]);
						errors++;
					end
					if (m_tdata[82:51] !== e.stores) begin
						$display("%0t: stores exp %0d act %0d", $time, e.stores, m_tdata[82:51]);
						errors++;
					end
					if (m_tdata[114:83] !== e.ld_hit_n) begin
						$display("%0t: load hit count exp %0d act %0d", $time, e.ld_hit_n,
							m_tdata[114:83]);
						errors++;
					end
					if (m_tdata[146:115] !== e.ld_miss_n) begin
						$display("%0t: load miss count exp %0d act %0d", $time, e.ld_miss_n,
							m_tdata[146:115]);
						errors++;
					end
					if (m_tdata[178:147] !== e.st_hit_n) begin
						$display("%0t: store hit count exp %0d act %0d", $time, e.st_hit_n,
							m_tdata[178:147]);
						errors++;
					end
					if (m_tdata[210:179] !== e.st_miss_n) begin
						$display("%0t: store miss count exp %0d act %0d", $time, e.st_miss_n,
							m_tdata[210:179]);
						errors++;
					end
					if (m_tdata[258:211] !== e.cycles) begin
						$display("%0t: cycles_so_far exp %0d act %0d", $time, e.cycles,
							m_tdata[258:211]);
						errors++;
					end
				end
			end
			// long hold-off, counted here, while the sender keeps offering
			if (hold_req && !hold_done) begin
				hold_done = 1;
				m_long = 300;
			end
			if (m_long > 0) begin
				m_long--;
				r = 0;
			end else if (m_stall > 0) begin
				m_stall--;
				r = 0;
			end else begin
				r = 1;
				if (!quiet && $urandom_range(0, 5) == 0) m_stall = $urandom_range(1, 18);
			end
			m_tready <= r;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT_CYCLES) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val[9:0];
		case (idx)
			REG_SET_BITS:  c_sb     = val & 4'hF;
			REG_WAYS:      c_ways   = val & 4'hF;
			REG_WORD_BITS: c_wb     = val & 3'h7;
			REG_ALLOC:     c_alloc  = val & 1;
			REG_WB:        c_wbmode = val & 1;
			REG_LRU:       c_lru    = val & 1;
			REG_MEM_PEN:   c_pen    = val & 10'h3FF;
			REG_HIT_CYC:   c_hit    = val & 4'hF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(int unsigned sb, int unsigned ways, int unsigned wb, int unsigned al,
			int unsigned wbm, int unsigned lru, int unsigned pen, int unsigned hc);
		reg_write(REG_SET_BITS, sb);
		reg_write(REG_WAYS, ways);
		reg_write(REG_WORD_BITS, wb);
		reg_write(REG_ALLOC, al);
		reg_write(REG_WB, wbm);
		reg_write(REG_LRU, lru);
		reg_write(REG_MEM_PEN, pen);
		reg_write(REG_HIT_CYC, hc);
	endtask

	task automatic push(logic op, logic [31:0] a);
		access_t t;
		t.op = op;
		t.addr = a;
		pending.insert(pending.size(), t);
	endtask

	// mostly a small pool of tags so that sets fill, hit and evict
	task automatic push_random(int n);
		int unsigned sb, wb, off, tg, st;
		logic [31:0] a;
		sb = (c_sb > 8) ? 8 : c_sb;
		wb = (c_wb > 6) ? 6 : c_wb;
		off = wb + 2;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				tg = $urandom_range(0, 11);
				st = $urandom_range(0, 3);
				a = (tg << (off + sb)) | ((st << off) & (((1 << sb) - 1) << off))
					| ($urandom & ((1 << off) - 1));
			end else
				a = $urandom;
			push(1'($urandom_range(0, 1)), a);
		end
	endtask

	// wait for all results, then let the pipeline settle
	task automatic drain;
		while (pending.size() > 0 || s_tvalid || expected.size() > 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		cyc = 0;
		quiet = 0;
		hold_req = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		c_sb = 0; c_ways = 1; c_wb = 0; c_alloc = 0;
		c_wbmode = 0; c_lru = 0; c_pen = 100; c_hit = 1;
		n_ld = 0; n_st = 0; n_ldh = 0; n_ldm = 0; n_sth = 0; n_stm = 0; n_cyc = 0;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			vld[i] = 0;
			drt[i] = 0;
			rank[i] = 0;
			tags[i] = '0;
		end
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: reset settings, then write-back with allocate in LRU
		push(OP_LOAD, 32'h0);
		push(OP_LOAD, 32'h0);
		push(OP_STORE, 32'h0);
		push(OP_STORE, 32'hFFFF_FFFF);
		push(OP_LOAD, 32'hFFFF_FFFF);
		push(OP_LOAD, 32'h8000_0004);
		drain();
		setup(2, 2, 1, 1, 1, 1, 1023, 15);
		push(OP_STORE, 32'h0000_0000);   // allocate, dirty
		push(OP_LOAD,  32'h0000_0020);   // second way, same set
		push(OP_LOAD,  32'h0000_0004);   // hit, becomes most recent
		push(OP_LOAD,  32'h0000_0040);   // evicts the clean block
		push(OP_LOAD,  32'h0000_0060);   // evicts the dirty one
		push(OP_STORE, 32'h0000_0060);
		push(OP_STORE, 32'hFFFF_FFFC);
		push(OP_LOAD,  32'hFFFF_FFFC);
		drain();
		// saturation cases: too many sets, out of range ways and words, zero costs
		setup(15, 15, 7, 1, 0, 0, 0, 0);
		push(OP_STORE, 32'h1234_5678);
		push(OP_STORE, 32'h1234_5678);
		push(OP_LOAD,  32'h0000_0000);
		push(OP_STORE, 32'h7FFF_FFFF);
		drain();

		// random phases
		setup(3, 8, 0, 1, 1, 1, 7, 3);
		push_random(120);
		drain();
		setup(3, 2, 0, 1, 1, 0, 50, 2);     // ways cut below the sets' fill
		hold_req = 1;
		push_random(120);
		drain();
		setup(8, 0, 6, 0, 0, 1, 1023, 15);
		push_random(110);
		drain();
		setup(0, 4, 3, 1, 0, 0, 20, 1);
		push_random(110);
		drain();
		setup(1, 3, 2, 0, 1, 1, 511, 8);
		push_random(110);
		drain();
		quiet = 1;
		setup(2, 8, 7, 1, 1, 0, 1023, 15);
		push_random(130);
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/sacc_pkg.sv
rtl/core/sacc_datapath.sv
rtl/core/sacc_ctrl.sv
rtl/core/set_assoc_cache_cycle_model_top.sv
tb/sv/tb.sv
